>>> rtl/hbd_pkg.sv
// Shared types and constants for the Huffman tree bit decoder.
`default_nettype none

package hbd_pkg;

   localparam int IDX_BITS            = 9;
   localparam int CODE_BITS           = 8;
   localparam int SYMBOL_OUT_BITS     = 8;
   localparam int MSB_POS             = 7;
   localparam int BIT_CNT_BITS        = $clog2(MSB_POS + 1);
   localparam int NODE_COUNT_DEFAULT  = 512;
   localparam int SYMBOL_BITS_DEFAULT = 8;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_DECODE = 1'b1
   } hbd_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LATCH,
      ST_WALK,
      ST_FINISH
   } hbd_state_type;

   // walker to output stage
   typedef struct packed {
      logic                       hit;
      logic [SYMBOL_OUT_BITS-1:0] symbol;
      logic                       flush;
   } hbd_emit_type;

endpackage

`default_nettype wire

>>> rtl/hbd_node_mem.sv
// Node table: synchronous RAM, one write and one registered read per cycle.
`default_nettype none

module hbd_node_mem #(
   parameter int NODE_COUNT = hbd_pkg::NODE_COUNT_DEFAULT,
   parameter int ENTRY_BITS = 1 + 2 * hbd_pkg::IDX_BITS + hbd_pkg::SYMBOL_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [hbd_pkg::IDX_BITS-1:0]  wr_idx,
   input  wire logic [ENTRY_BITS-1:0]         wr_data,
   input  wire logic [hbd_pkg::IDX_BITS-1:0]  rd_idx,
   output logic      [ENTRY_BITS-1:0]         rd_data
);

   localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

   logic [ENTRY_BITS-1:0] mem [NODE_COUNT];
   logic [ENTRY_BITS-1:0] q_ff;
   logic                  rd_ok_ff;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;

   assign wr_addr = AW'(wr_idx);
   assign rd_addr = AW'(rd_idx);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_ff     <= mem[rd_addr];
      rd_ok_ff <= (32'(rd_idx) < NODE_COUNT);
   end

   // index beyond the table reads as an all-zero node
   assign rd_data = rd_ok_ff ? q_ff : '0;

endmodule

`default_nettype wire

>>> rtl/hbd_out_stage.sv
// Output stage: holds one symbol back so the last symbol of a byte can be flagged.
`default_nettype none

module hbd_out_stage (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire hbd_pkg::hbd_emit_type                  emit,
   output logic                                        rsp_strobe,
   output logic      [hbd_pkg::SYMBOL_OUT_BITS-1:0]    rsp_symbol,
   output logic                                        rsp_last
);

   logic                                 pend_valid_ff, pend_valid_in;
   logic [hbd_pkg::SYMBOL_OUT_BITS-1:0]  pend_sym_ff, pend_sym_in;
   logic                                 strobe_ff, strobe_in;
   logic [hbd_pkg::SYMBOL_OUT_BITS-1:0]  sym_ff;
   logic                                 last_ff;

   // a new hit releases the held symbol; flush releases it as the last one
   always_comb begin
      strobe_in     = pend_valid_ff && (emit.hit || emit.flush);
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      if (emit.hit) begin
         pend_valid_in = 1'b1;
         pend_sym_in   = emit.symbol;
      end else if (emit.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_sym_ff <= pend_sym_in;
      if (strobe_in) begin
         sym_ff  <= pend_sym_ff;
         last_ff <= emit.flush;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_symbol = sym_ff;
   assign rsp_last   = strobe_ff && last_ff;

endmodule

`default_nettype wire

>>> rtl/huffman_tree_bit_decoder.sv
// Top level: Huffman code tree walker over a node table RAM.
//
// Usage: a command is taken at a rising edge with start high and busy low.
// req_op selects a node load (writes one table entry) or a byte decode.
// A load never raises busy. A decode walks the eight bits of req_code_byte
// MSB first, one node table read per bit: the registered RAM read sets the
// pace of one bit per cycle, and busy is high for 8 bit steps and one
// closing step per byte. After reset or a csr_wr_en write of the root
// index, the first decode also passes through ST_FETCH and ST_LATCH to
// fetch the root node into its cache.
// Each decoded symbol appears on rsp_symbol for one cycle with rsp_strobe
// high; rsp_last marks the final symbol of a byte. A byte that reaches no
// leaf yields no transfer. Symbols trail their tree step by one held slot;
// the last symbol of a byte is presented in the cycle after busy falls.
// The receiver cannot stall: every strobe is a completed transfer.
// Reset sets the root index and the walk position to 0; table contents
// stay undefined until loaded. Write csr only while no byte is in flight.
`default_nettype none

module huffman_tree_bit_decoder #(
   parameter int NODE_COUNT  = hbd_pkg::NODE_COUNT_DEFAULT,
   parameter int SYMBOL_BITS = hbd_pkg::SYMBOL_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_op,
   input  wire logic [hbd_pkg::IDX_BITS-1:0]         req_node_index,
   input  wire logic                                 req_node_is_leaf,
   input  wire logic [hbd_pkg::IDX_BITS-1:0]         req_left_child,
   input  wire logic [hbd_pkg::IDX_BITS-1:0]         req_right_child,
   input  wire logic [7:0]                           req_leaf_symbol,
   input  wire logic [hbd_pkg::CODE_BITS-1:0]        req_code_byte,
   output logic                                      rsp_strobe,
   output logic      [hbd_pkg::SYMBOL_OUT_BITS-1:0]  rsp_symbol,
   output logic                                      rsp_last,
   input  wire logic                                 csr_wr_en,
   input  wire logic [hbd_pkg::IDX_BITS-1:0]         csr_wr_data
);

   localparam int IW  = hbd_pkg::IDX_BITS;
   localparam int EW  = 1 + 2 * IW + SYMBOL_BITS;
   localparam int CW  = hbd_pkg::BIT_CNT_BITS;

   hbd_pkg::hbd_state_type state_ff, state_in;

   logic [CW-1:0]                  bit_cnt_ff;
   logic [hbd_pkg::CODE_BITS-1:0]  byte_ff;
   logic [IW-1:0]                  root_node_ff;
   logic [IW-1:0]                  cur_node_ff;
   logic [IW-1:0]                  prev_idx_ff;
   logic [EW-1:0]                  cur_entry_ff;
   logic [EW-1:0]                  root_entry_ff;
   logic                           cache_ok_ff;
   logic                           flush_ff;

   logic            load_acc, decode_acc, load_in_range;
   logic            eval, rd_leaf, hit, step_bit, last_bit;
   logic [EW-1:0]   wr_data, rd_data, cur_ent;
   logic [IW-1:0]   rd_idx, cur_idx, next_idx;
   hbd_pkg::hbd_emit_type emit;

   assign load_acc      = start && !busy && (req_op == hbd_pkg::OP_LOAD);
   assign decode_acc    = start && !busy && (req_op == hbd_pkg::OP_DECODE);
   assign load_in_range = (32'(req_node_index) < NODE_COUNT);
   assign wr_data       = {req_node_is_leaf, req_left_child, req_right_child,
                           SYMBOL_BITS'(req_leaf_symbol)};

   // data from the previous bit's read is present from the second step on
   assign eval     = ((state_ff == hbd_pkg::ST_WALK) && (bit_cnt_ff != '0))
                     || (state_ff == hbd_pkg::ST_FINISH);
   assign rd_leaf  = rd_data[EW-1];
   assign hit      = eval && rd_leaf;
   assign last_bit = (bit_cnt_ff == CW'(hbd_pkg::MSB_POS));
   assign step_bit = byte_ff[hbd_pkg::MSB_POS];

   // on a leaf the walk resumes from the cached root entry
   always_comb begin
      if (!eval) begin
         cur_ent = cur_entry_ff;
         cur_idx = cur_node_ff;
      end else if (rd_leaf) begin
         cur_ent = root_entry_ff;
         cur_idx = root_node_ff;
      end else begin
         cur_ent = rd_data;
         cur_idx = prev_idx_ff;
      end
   end

   assign next_idx = step_bit ? cur_ent[SYMBOL_BITS +: IW]
                              : cur_ent[SYMBOL_BITS + IW +: IW];

   hbd_node_mem #(
      .NODE_COUNT (NODE_COUNT),
      .ENTRY_BITS (EW)
   ) u_node_mem (
      .clock   (clock),
      .wr_en   (load_acc && load_in_range),
      .wr_idx  (req_node_index),
      .wr_data (wr_data),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hbd_pkg::ST_IDLE: begin
            if (decode_acc) begin
               state_in = cache_ok_ff ? hbd_pkg::ST_WALK : hbd_pkg::ST_FETCH;
            end
         end
         hbd_pkg::ST_FETCH:  state_in = hbd_pkg::ST_LATCH;
         hbd_pkg::ST_LATCH:  state_in = hbd_pkg::ST_WALK;
         hbd_pkg::ST_WALK: begin
            if (last_bit) begin
               state_in = hbd_pkg::ST_FINISH;
            end
         end
         hbd_pkg::ST_FINISH: state_in = hbd_pkg::ST_IDLE;
         default:            state_in = hbd_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      busy        = 1'b1;
      rd_idx      = next_idx;
      emit.hit    = hit;
      emit.symbol = hbd_pkg::SYMBOL_OUT_BITS'(rd_data[SYMBOL_BITS-1:0]);
      emit.flush  = flush_ff;
      case (state_ff)
         hbd_pkg::ST_IDLE:   busy   = 1'b0;
         hbd_pkg::ST_FETCH:  rd_idx = root_node_ff;
         default:            busy   = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hbd_pkg::ST_IDLE;
         bit_cnt_ff   <= '0;
         root_node_ff <= '0;
         cur_node_ff  <= '0;
         cache_ok_ff  <= 1'b0;
         flush_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         flush_ff   <= (state_ff == hbd_pkg::ST_FINISH);
         bit_cnt_ff <= (state_ff == hbd_pkg::ST_WALK) ? bit_cnt_ff + 1'b1 : '0;
         if (csr_wr_en) begin
            root_node_ff <= csr_wr_data;
            cur_node_ff  <= csr_wr_data;
            cache_ok_ff  <= 1'b0;
         end
         if (state_ff == hbd_pkg::ST_LATCH) begin
            cache_ok_ff <= 1'b1;
         end
         if (state_ff == hbd_pkg::ST_FINISH) begin
            cur_node_ff <= cur_idx;
         end
      end
   end

   // payload: byte shifter, issued index, node caches (kept coherent with loads)
   always_ff @(posedge clock) begin
      if (decode_acc) begin
         byte_ff <= req_code_byte;
      end else if (state_ff == hbd_pkg::ST_WALK) begin
         byte_ff <= byte_ff << 1;
      end
      prev_idx_ff <= next_idx;
      if (load_acc && load_in_range) begin
         if (req_node_index == root_node_ff) begin
            root_entry_ff <= wr_data;
         end
         if (req_node_index == cur_node_ff) begin
            cur_entry_ff <= wr_data;
         end
      end
      if (state_ff == hbd_pkg::ST_LATCH) begin
         root_entry_ff <= rd_data;
         cur_entry_ff  <= rd_data;
      end else if (state_ff == hbd_pkg::ST_FINISH) begin
         cur_entry_ff <= cur_ent;
      end
   end

   hbd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .rsp_strobe (rsp_strobe),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

   a_decode_goes_busy: assert property (@(posedge clock) disable iff (reset)
      decode_acc |=> busy)
      else $error("decode transfer did not raise busy");

   a_eighth_step_finishes: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == hbd_pkg::ST_WALK) && last_bit) |=> (state_ff == hbd_pkg::ST_FINISH))
      else $error("walk did not close after the eighth bit");

   a_finish_releases: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hbd_pkg::ST_FINISH) |=> (!busy && flush_ff))
      else $error("closing step did not release busy and flush");

   a_cold_cache_at_root: assert property (@(posedge clock) disable iff (reset)
      !cache_ok_ff |-> (cur_node_ff == root_node_ff))
      else $error("walk left the root while the node cache was cold");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the Huffman tree bit decoder.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_BITS        = hbd_pkg::IDX_BITS;
   localparam int CODE_BITS       = hbd_pkg::CODE_BITS;
   localparam int SYMBOL_OUT_BITS = hbd_pkg::SYMBOL_OUT_BITS;
   localparam int MSB_POS         = hbd_pkg::MSB_POS;

   localparam int TABLE_SIZE    = 512;
   localparam int RANDOM_ITEMS  = 180;
   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 300000;

   typedef struct {
      hbd_pkg::hbd_op_type  op;
      logic [IDX_BITS-1:0]  node_index;
      logic                 node_is_leaf;
      logic [IDX_BITS-1:0]  left_child;
      logic [IDX_BITS-1:0]  right_child;
      logic [7:0]           leaf_symbol;
      logic [CODE_BITS-1:0] code_byte;
   } code_item_type;

   typedef struct {
      logic [SYMBOL_OUT_BITS-1:0] symbol;
      logic                       last;
   } sym_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic                 req_op           = 1'b0;
   logic [IDX_BITS-1:0]  req_node_index   = '0;
   logic                 req_node_is_leaf = 1'b0;
   logic [IDX_BITS-1:0]  req_left_child   = '0;
   logic [IDX_BITS-1:0]  req_right_child  = '0;
   logic [7:0]           req_leaf_symbol  = '0;
   logic [CODE_BITS-1:0] req_code_byte    = '0;
   logic                       rsp_strobe;
   logic [SYMBOL_OUT_BITS-1:0] rsp_symbol;
   logic                       rsp_last;
   logic                 csr_wr_en   = 1'b0;
   logic [IDX_BITS-1:0]  csr_wr_data = '0;

   huffman_tree_bit_decoder uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_node_index   (req_node_index),
      .req_node_is_leaf (req_node_is_leaf),
      .req_left_child   (req_left_child),
      .req_right_child  (req_right_child),
      .req_leaf_symbol  (req_leaf_symbol),
      .req_code_byte    (req_code_byte),
      .rsp_strobe       (rsp_strobe),
      .rsp_symbol       (rsp_symbol),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   bit                 node_leaf  [TABLE_SIZE];
   bit [IDX_BITS-1:0]  node_left  [TABLE_SIZE];
   bit [IDX_BITS-1:0]  node_right [TABLE_SIZE];
   bit [7:0]           node_sym   [TABLE_SIZE];
   bit [IDX_BITS-1:0]  root_idx  = '0;
   bit [IDX_BITS-1:0]  walk_node = '0;
   sym_result_type     expected_syms[$];

   // stimulus bookkeeping
   code_item_type pending_items[$];
   code_item_type drive_item;
   int       issued      = 0;
   int       accepted    = 0;
   int       idle_pct    = 30;
   int       error_count = 0;
   int       cycle_count = 0;
   int       item_total  = 0;
   bit       node_loaded [TABLE_SIZE];
   bit       tree_used   [TABLE_SIZE];
   int       loaded_list[$];

   task automatic walk_code_byte(input logic [CODE_BITS-1:0] code);
      sym_result_type    found[$];
      sym_result_type    r;
      logic [IDX_BITS-1:0] nxt;
      int                b;
      for (b = MSB_POS; b >= 0; b--) begin
         nxt = code[b] ? node_right[walk_node] : node_left[walk_node];
         walk_node = nxt;
         if (node_leaf[nxt]) begin
            r.symbol = node_sym[nxt];
            r.last   = 1'b0;
            found.push_back(r);
            walk_node = root_idx;
         end
      end
      if (found.size() != 0) found[found.size()-1].last = 1'b1;
      foreach (found[i]) expected_syms.push_back(found[i]);
   endtask

   task automatic apply_item(input code_item_type it);
      if (it.op == hbd_pkg::OP_LOAD) begin
         node_leaf[it.node_index]  = it.node_is_leaf;
         node_left[it.node_index]  = it.left_child;
         node_right[it.node_index] = it.right_child;
         node_sym[it.node_index]   = it.leaf_symbol;
      end else begin
         walk_code_byte(it.code_byte);
      end
   endtask

   // driver: inputs change on the falling edge
   always @(negedge clock) begin
      if (reset || issued != accepted) begin
         // hold the current item until its transfer
      end else if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
         drive_item = pending_items.pop_front();
         start            <= 1'b1;
         req_op           <= drive_item.op;
         req_node_index   <= drive_item.node_index;
         req_node_is_leaf <= drive_item.node_is_leaf;
         req_left_child   <= drive_item.left_child;
         req_right_child  <= drive_item.right_child;
         req_leaf_symbol  <= drive_item.leaf_symbol;
         req_code_byte    <= drive_item.code_byte;
         issued++;
      end else begin
         start            <= 1'b0;
         req_op           <= 1'($urandom_range(1));
         req_node_index   <= IDX_BITS'($urandom_range(511));
         req_node_is_leaf <= 1'($urandom_range(1));
         req_left_child   <= IDX_BITS'($urandom_range(511));
         req_right_child  <= IDX_BITS'($urandom_range(511));
         req_leaf_symbol  <= 8'($urandom_range(255));
         req_code_byte    <= CODE_BITS'($urandom_range(255));
      end
   end

   // monitor: everything sampled on the rising edge
   always @(posedge clock) begin
      sym_result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else if (!reset) begin
         if (rsp_strobe) begin
            if (expected_syms.size() == 0) begin
               $error("unexpected symbol transfer: symbol %0h last %0b", rsp_symbol, rsp_last);
               error_count++;
            end else begin
               want = expected_syms.pop_front();
               if (rsp_symbol !== want.symbol) begin
                  $error("symbol: expected %0h actual %0h", want.symbol, rsp_symbol);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b actual %0b", want.last, rsp_last);
                  error_count++;
               end
            end
         end
         if (csr_wr_en) begin
            root_idx  = csr_wr_data;
            walk_node = csr_wr_data;
         end
         if (start && !busy) begin
            apply_item(drive_item);
            accepted++;
         end
      end
   end

   function automatic int any_loaded(input int self_idx);
      if (loaded_list.size() == 0) return self_idx;
      return loaded_list[$urandom_range(loaded_list.size() - 1)];
   endfunction

   task automatic push_load(input int idx, input bit leaf, input int lc, input int rc,
                            input int sym);
      code_item_type it;
      it.op           = hbd_pkg::OP_LOAD;
      it.node_index   = IDX_BITS'(idx);
      it.node_is_leaf = leaf;
      it.left_child   = IDX_BITS'(lc);
      it.right_child  = IDX_BITS'(rc);
      it.leaf_symbol  = 8'(sym);
      it.code_byte    = CODE_BITS'($urandom_range(255));
      pending_items.push_back(it);
      if (!node_loaded[idx]) begin
         node_loaded[idx] = 1'b1;
         loaded_list.push_back(idx);
      end
      item_total++;
   endtask

   task automatic push_decode(input int code);
      code_item_type it;
      it.op           = hbd_pkg::OP_DECODE;
      it.node_index   = IDX_BITS'($urandom_range(511));
      it.node_is_leaf = 1'($urandom_range(1));
      it.left_child   = IDX_BITS'($urandom_range(511));
      it.right_child  = IDX_BITS'($urandom_range(511));
      it.leaf_symbol  = 8'($urandom_range(255));
      it.code_byte    = CODE_BITS'(code);
      pending_items.push_back(it);
      item_total++;
   endtask

   // every node loaded here only points at nodes already loaded (or itself),
   // so no walk can ever read an unwritten entry
   task automatic noise_load();
      int idx;
      idx = $urandom_range(511);
      push_load(idx, 1'($urandom_range(1)), any_loaded(idx), any_loaded(idx),
                $urandom_range(255));
   endtask

   // children are loaded before their parent
   task automatic build_subtree(input int leaves, input int want_idx, input bit skew,
                                output int idx);
      int n_left;
      int lc;
      int rc;
      if (want_idx >= 0) begin
         idx = want_idx;
      end else begin
         idx = $urandom_range(511);
         while (tree_used[idx]) idx = $urandom_range(511);
      end
      tree_used[idx] = 1'b1;
      if (leaves == 1) begin
         push_load(idx, 1'b1, any_loaded(idx), any_loaded(idx), $urandom_range(255));
      end else begin
         n_left = skew ? 1 : $urandom_range(leaves - 1, 1);
         build_subtree(n_left, -1, skew, lc);
         build_subtree(leaves - n_left, -1, skew, rc);
         push_load(idx, 1'b0, lc, rc, $urandom_range(255));
      end
   endtask

   task automatic wait_quiet(input int settle);
      @(negedge clock);
      while (pending_items.size() != 0 || issued != accepted || busy ||
             expected_syms.size() != 0)
         @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_root(input int idx);
      wait_quiet(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= IDX_BITS'(idx);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= IDX_BITS'($urandom_range(511));
   endtask

   initial begin
      int directed_total;
      int n;
      int phase_no;
      int top;
      int n_bytes;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset root 0: all-zero and all-one bytes give eight symbols each
      push_load(0, 1'b0, 1, 511, 8'h5A);
      push_load(1, 1'b1, 0, 0, 8'h00);
      push_load(511, 1'b1, 511, 511, 8'hFF);
      push_load(2, 1'b0, 2, 1, 8'h33);
      push_decode(8'h00);
      push_decode(8'hFF);
      push_decode(8'hA5);
      // self loop on zero: a byte with no symbol, walk stays put
      write_root(2);
      push_decode(8'h00);
      push_decode(8'h01);
      push_decode(8'h80);
      // leaf as root: the walk still steps to a child first
      write_root(511);
      push_decode(8'h3C);
      // root write in the middle of a code restarts the walk
      push_load(6, 1'b0, 7, 1, 8'h11);
      push_load(7, 1'b0, 511, 7, 8'h22);
      write_root(6);
      push_decode(8'h01);
      write_root(6);
      push_decode(8'h80);
      // root node overwritten after it was first used
      push_load(6, 1'b0, 1, 511, 8'h44);
      push_decode(8'h5A);
      wait_quiet(0);

      directed_total = item_total;
      phase_no = 0;
      while (item_total - directed_total < RANDOM_ITEMS) begin
         n = item_total - directed_total;
         idle_pct = (n < 70) ? 30 : (n < 140) ? 64 : 0;
         phase_no++;
         foreach (tree_used[i]) tree_used[i] = 1'b0;
         build_subtree($urandom_range(12, 2),
                       (phase_no == 1) ? 511 : (phase_no == 3) ? 0 : -1,
                       ($urandom_range(3) == 0), top);
         write_root(top);
         n_bytes = $urandom_range(28, 16);
         for (int k = 0; k < n_bytes; k++) begin
            // sender holds off until the decoder has drained
            if (k == n_bytes / 2) wait_quiet(0);
            if ($urandom_range(99) < 12) noise_load();
            else push_decode($urandom_range(255));
         end
      end

      wait_quiet(SETTLE_CYCLES);
      if (error_count == 0 && expected_syms.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
